@@ rtl/ordered_list_insert_erase_core_macros.svh @@
// assertion macros for the ordered list checker
// depends on nothing; included by the checker file only
`ifndef ORDERED_LIST_INSERT_ERASE_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_ERASE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define OLIE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define OLIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/olie_pkg.sv @@
// shared types and constants of the ordered list core
// used by the cell row, the control unit, the top level and the checker
package olie_pkg;

    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = 7;
    localparam int OUT_COUNT_W = 7;
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SHIFT_HOLD = 2'd0,
        SHIFT_UP   = 2'd1,
        SHIFT_DOWN = 2'd2
    } t_shift_op;

    typedef struct packed {
        t_cmd        cmd;
        logic [6:0]  position;
        logic [31:0] entry_in;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        logic [31:0] entry_out;
        logic [6:0]  count;
    } t_out_beat;

    // broadcast to every cell of the row
    typedef struct packed {
        t_shift_op              op;
        logic [IDX_W-1:0]       idx;
        logic [DATA_WIDTH-1:0]  data;
    } t_shift_ctrl;

endpackage

@@ rtl/olie_cell.sv @@
// one storage cell of the list row
// takes its left or right neighbor, new data, or holds; uses olie_pkg
module olie_cell
    import olie_pkg::*;
(
    input  logic                  i_clk,
    input  logic [IDX_W-1:0]      i_idx,
    input  t_shift_ctrl           i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_entry
);

    logic [DATA_WIDTH-1:0] r_entry;
    logic [DATA_WIDTH-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            SHIFT_UP: begin
                if (i_idx == i_ctrl.idx) begin
                    n_entry = i_ctrl.data;
                end else if (i_idx > i_ctrl.idx) begin
                    n_entry = i_left;
                end
            end
            SHIFT_DOWN: begin
                if (i_idx >= i_ctrl.idx) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/olie_ctrl.sv @@
// command decode, range checks and entry count register
// drives the shift control of the cell row; uses olie_pkg
module olie_ctrl
    import olie_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_in_beat         i_beat,
    output t_shift_ctrl      o_shift,
    output t_status          o_status,
    output logic             o_rd_en,
    output logic [CNT_W-1:0] o_count
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    t_shift_op        op;

    assign pos_ext = CMP_W'(i_beat.position);
    assign cnt_ext = CMP_W'(r_count);
    assign full    = (r_count == CNT_W'(DEPTH));

    always_comb begin
        n_count  = r_count;
        o_status = ST_OK;
        o_rd_en  = 1'b0;
        op       = SHIFT_HOLD;
        case (i_beat.cmd)
            CMD_INSERT: begin
                // full is checked before position
                if (full) begin
                    o_status = ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    o_status = ST_RANGE;
                end else begin
                    op      = SHIFT_UP;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_ERASE: begin
                if (pos_ext >= cnt_ext) begin
                    o_status = ST_RANGE;
                end else begin
                    op      = SHIFT_DOWN;
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_READ: begin
                if (pos_ext >= cnt_ext) begin
                    o_status = ST_RANGE;
                end else begin
                    o_rd_en = 1'b1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    // an accepted position is always below DEPTH, so the low bits index a cell
    assign o_shift.op   = i_fire ? op : SHIFT_HOLD;
    assign o_shift.idx  = i_beat.position[IDX_W-1:0];
    assign o_shift.data = i_beat.entry_in[DATA_WIDTH-1:0];
    assign o_count      = n_count;

endmodule

@@ rtl/ordered_list_insert_erase_core.sv @@
// ordered list core: row of entry cells, control unit and result register
// depends on olie_pkg, olie_ctrl and olie_cell
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+------------------------
//   command  | in        | i_in_valid / o_in_ready    | i_in_beat  (t_in_beat)
//   result   | out       | o_out_valid / i_out_ready  | o_out_beat (t_out_beat)
//
// one command per cycle unless a stalled result holds it: all cells shift in
// parallel on the accepting edge, and the result is registered on that edge too.
// a new command is taken while the output register is empty or being drained.
// a stalled result stalls the command side only when it is not taken.
// synchronous active-low reset empties the list and the output register;
// the entry cells themselves are not cleared.
module ordered_list_insert_erase_core
    import olie_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic                  fire;
    t_shift_ctrl           shift;
    t_status               status;
    logic                  rd_en;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] cell_entry [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data;

    logic      r_out_valid;
    t_out_beat r_out_beat;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    olie_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_beat   (i_in_beat),
        .o_shift  (shift),
        .o_status (status),
        .o_rd_en  (rd_en),
        .o_count  (count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        logic [DATA_WIDTH-1:0] right;

        // the end cells never take from the missing side
        if (g == 0) begin : g_first
            assign left = cell_entry[g];
        end else begin : g_mid_l
            assign left = cell_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right = cell_entry[g];
        end else begin : g_mid_r
            assign right = cell_entry[g+1];
        end

        olie_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctrl  (shift),
            .i_left  (left),
            .i_right (right),
            .o_entry (cell_entry[g])
        );
    end

    assign rd_data = rd_en ? cell_entry[i_in_beat.position[IDX_W-1:0]] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_beat.status    <= status;
            r_out_beat.entry_out <= 32'(rd_data);
            r_out_beat.count     <= OUT_COUNT_W'(count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

@@ rtl/olie_checker.sv @@
// port-level checks on the ordered list core, bound to the top level
// depends on olie_pkg and ordered_list_insert_erase_core_macros.svh
`include "ordered_list_insert_erase_core_macros.svh"

module olie_checker
    import olie_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_beat
);

    // a stalled result beat holds
    `OLIE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_beat), "result beat dropped or changed while stalled")

    `OLIE_ASSERT_NOW(a_count_max, i_clk, i_rst_n, o_out_valid, o_out_beat.count <= OUT_COUNT_W'(DEPTH), "count beyond capacity")

    `OLIE_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_out_valid && o_out_beat.status == ST_FULL, o_out_beat.count == OUT_COUNT_W'(DEPTH), "full status with a list that is not full")

    // an accepted clear always leaves an empty list with ok status
    `OLIE_ASSERT_NEXT(a_clear, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_beat.cmd == CMD_CLEAR, o_out_valid && o_out_beat.count == '0 && o_out_beat.status == ST_OK, "clear did not empty the list")

endmodule

bind ordered_list_insert_erase_core olie_checker u_olie_checker (.*);

@@ dv/tb_top.sv @@
// self-checking testbench for ordered_list_insert_erase_core: directed and random
// commands are checked against an in-bench model of the list
// depends on olie_pkg and the core rtl only
module tb_top;
    import olie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_beat  = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_beat;

    // model of the list contents and length
    logic [DATA_WIDTH-1:0] list_store [DEPTH];
    int                    list_len = 0;
    t_out_beat             pending_results [$];

    int mismatch_count  = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    ordered_list_insert_erase_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // applies one command to the model and returns the result it gives
    function automatic t_out_beat apply_list_cmd(t_in_beat beat);
        t_out_beat res;
        int        p;
        int        i;
        p             = int'(beat.position);
        res.status    = ST_OK;
        res.entry_out = '0;
        case (beat.cmd)
            CMD_INSERT: begin
                if (list_len >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (p > list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = list_len; i > p; i--)
                        list_store[IDX_W'(i)] = list_store[IDX_W'(i-1)];
                    list_store[IDX_W'(p)] = beat.entry_in[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            CMD_ERASE: begin
                if (p >= list_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (i = p + 1; i < list_len; i++)
                        list_store[IDX_W'(i-1)] = list_store[IDX_W'(i)];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (p >= list_len) res.status = ST_RANGE;
                else res.entry_out = 32'(list_store[IDX_W'(p)]);
            end
            default: begin
                list_len = 0;
            end
        endcase
        res.count = 7'(list_len);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        $display("[%0t] mismatch %s: expected 0x%0h got 0x%0h", $realtime, what, want, got);
    endtask

    // result side: random stalls, one compare per accepted beat
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", '0, 32'(o_out_beat.count));
            end else begin
                want = pending_results.pop_front();
                if (o_out_beat.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_out_beat.status));
                if (o_out_beat.entry_out !== want.entry_out)
                    report_mismatch("entry_out", want.entry_out, o_out_beat.entry_out);
                if (o_out_beat.count !== want.count)
                    report_mismatch("count", 32'(want.count), 32'(o_out_beat.count));
            end
        end
    end

    // sends one command beat; valid drops only while the sender idles
    task automatic send_cmd(t_cmd cmd, int pos, logic [31:0] data);
        t_in_beat beat;
        beat.cmd      = cmd;
        beat.position = 7'(pos);
        beat.entry_in = data;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(apply_list_cmd(beat));
    endtask

    task automatic test_empty_list();
        send_cmd(CMD_READ, 0, 32'h0);
        send_cmd(CMD_ERASE, 0, 32'h0);
        send_cmd(CMD_READ, 127, 32'hffff_ffff);
        send_cmd(CMD_ERASE, 127, 32'h0);
        send_cmd(CMD_INSERT, 1, 32'h1234_5678);
        send_cmd(CMD_INSERT, 127, 32'hffff_ffff);
    endtask

    task automatic test_push_pop();
        send_cmd(CMD_INSERT, 0, 32'h0000_0000);
        send_cmd(CMD_INSERT, 0, 32'hffff_ffff);
        send_cmd(CMD_INSERT, 2, 32'ha5a5_a5a5);
        send_cmd(CMD_INSERT, 1, 32'h5a5a_5a5a);
        for (int i = 0; i < 5; i++) send_cmd(CMD_READ, i, 32'h0);
        send_cmd(CMD_ERASE, 3, 32'h0);
        send_cmd(CMD_ERASE, 0, 32'h0);
        send_cmd(CMD_READ, 0, 32'h0);
        send_cmd(CMD_READ, 1, 32'h0);
        send_cmd(CMD_CLEAR, 0, 32'h0);
        send_cmd(CMD_READ, 0, 32'h0);
    endtask

    task automatic test_full_list();
        while (list_len < DEPTH) send_cmd(CMD_INSERT, list_len, $urandom());
        // the full check wins over the position check
        send_cmd(CMD_INSERT, 0, 32'hdead_beef);
        send_cmd(CMD_INSERT, 127, 32'hdead_beef);
        send_cmd(CMD_READ, DEPTH - 1, 32'h0);
        send_cmd(CMD_READ, DEPTH, 32'h0);
        send_cmd(CMD_ERASE, DEPTH, 32'h0);
        send_cmd(CMD_ERASE, DEPTH - 1, 32'h0);
        send_cmd(CMD_INSERT, DEPTH, 32'h0);
        send_cmd(CMD_INSERT, DEPTH - 1, 32'hffff_ffff);
        send_cmd(CMD_READ, DEPTH - 1, 32'h0);
        send_cmd(CMD_ERASE, 0, 32'h0);
        send_cmd(CMD_CLEAR, 5, 32'h0);
    endtask

    // mostly in-range commands; insert_pct steers the list toward full or empty
    task automatic random_cmds(int n, int insert_pct);
        int   r;
        t_cmd cmd;
        int   pos;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(999);
            if (r < insert_pct * 10) begin
                cmd = CMD_INSERT;
                pos = $urandom_range(list_len);
            end else if (r < 950) begin
                cmd = $urandom_range(1) ? CMD_ERASE : CMD_READ;
                pos = (list_len == 0) ? 0 : $urandom_range(list_len - 1);
            end else if (r < 955) begin
                cmd = CMD_CLEAR;
                pos = $urandom_range(127);
            end else begin
                cmd = t_cmd'($urandom_range(2));
                pos = $urandom_range(127);
            end
            send_cmd(cmd, pos, $urandom());
        end
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_chance);
        sender_idle_pct = idle_pct;
        stall_pct       = stall_chance;
        random_cmds(140, 75);
        random_cmds(140, 15);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_push_pop();
        test_full_list();
        test_random_traffic(0, 0);
        test_random_traffic(70, 0);
        test_random_traffic(0, 70);
        test_random_traffic(13, 13);

        sender_idle_pct = 0;
        stall_pct       = 0;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
